@@ hw/rtl/ufjq_pkg.sv @@
// Shared types and constants for the urgent-first job queue.
// No dependencies; imported by the queue top level and its checker.
package ufjq_pkg;

	// Default number of queue entries
	localparam int DEF_QUEUE_DEPTH = 16;

	// Field widths
	localparam int DOC_W     = 31;
	localparam int ID_W      = 37;
	localparam int PRI_W     = 8;
	localparam int FILL_W    = 5;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 80;
	localparam int M_TDATA_W = 88;

	// Priority value that marks an urgent job
	localparam logic [PRI_W-1:0] URGENT_PRIORITY = 8'd1;

	// Result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 2'd0,
		ST_SERVED   = 2'd1,
		ST_EMPTY    = 2'd2,
		ST_FULL     = 2'd3
	} status_t;

	// One queue entry
	typedef struct packed {
		logic [PRI_W-1:0] pri;
		logic [ID_W-1:0]  id;
		logic [DOC_W-1:0] doc;
	} job_t;

endpackage

@@ hw/rtl/urgent_first_job_queue.sv @@
// Urgent-first job queue: ordered entry memory plus a small sequencer that
// scans for the newest urgent job (else the oldest) and closes the gap after removal.
// Depends on ufjq_pkg.
//
//  channel  | dir | tdata (low bit up)                          | tuser
//  ---------+-----+---------------------------------------------+--------------
//  s_axis   | in  | doc_number, id_code, priority_req, pad      | mode
//  m_axis   | out | served_doc, served_id, served_priority,     | status
//           |     | served_urgent, fill_level, pad              |
//
// An insert, a full drop or an empty serve goes from IDLE through DONE into
// the output register. A serve scans the entries from the newest down to the
// picked one, then shifts the entries above it one slot down, then passes
// through DONE; the single read and single write port of the entry memory
// make the scan and the shift go entry by entry. One request is in work at a
// time.
// The entry memory needs no clearing after reset; the job count (count_q) resets to zero.
// A finished result waits in the output register while the next request
// is taken.
module urgent_first_job_queue #(
	parameter int QUEUE_DEPTH = ufjq_pkg::DEF_QUEUE_DEPTH
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// [30:0] doc_number, [67:31] id_code, [75:68] priority_req, [79:76] zero
	input  logic [ufjq_pkg::S_TDATA_W-1:0] s_axis_tdata,
	// [0] mode
	input  logic                           s_axis_tuser,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// [30:0] served_doc, [67:31] served_id, [75:68] served_priority,
	// [76] served_urgent, [81:77] fill_level, [87:82] zero
	output logic [ufjq_pkg::M_TDATA_W-1:0] m_axis_tdata,
	// [1:0] status
	output logic [ufjq_pkg::STATUS_W-1:0]  m_axis_tuser
);
	import ufjq_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int XW = AW + 1;
	localparam int FW = (CW > FILL_W) ? CW : FILL_W;
	localparam int PAD_W = M_TDATA_W - (DOC_W + ID_W + PRI_W + 1 + FILL_W);

	typedef enum logic [1:0] {
		IDLE,
		SCAN,
		SHIFT,
		DONE
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [AW-1:0]   scan_idx_q;
	logic            scan_run_q;
	logic            chk_vld_s1;
	logic [AW-1:0]   chk_idx_s1;
	logic [AW-1:0]   sh_idx_q;
	logic            wr_vld_s1;
	logic [AW-1:0]   wr_idx_s1;
	job_t            rdata_q;
	status_t         res_status_q;
	job_t            res_job_q;
	logic            res_urg_q;
	logic            m_vld_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic [STATUS_W-1:0]  m_user_q;

	job_t            mem [QUEUE_DEPTH];

	job_t            job_in;
	logic            accept;
	logic            is_full;
	logic            sh_more;
	logic [CW-1:0]   cnt_m1;
	logic [AW-1:0]   rd_addr;
	logic            we;
	logic [AW-1:0]   waddr;
	job_t            wdata;
	logic            pick_hit;
	logic [FW-1:0]   fill_ext;

	// Request unpacking and handshake
	assign job_in.doc    = s_axis_tdata[DOC_W-1:0];
	assign job_in.id     = s_axis_tdata[DOC_W+ID_W-1:DOC_W];
	assign job_in.pri    = s_axis_tdata[DOC_W+ID_W+PRI_W-1:DOC_W+ID_W];
	assign s_axis_tready = (state_q == IDLE);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_full       = (count_q == CW'(QUEUE_DEPTH));
	assign cnt_m1        = count_q - CW'(1);

	// More entries above the gap to move down
	assign sh_more = (XW'(sh_idx_q) + XW'(1)) < XW'(count_q);

	// Scan stops at the newest urgent entry or at the oldest one
	assign pick_hit = chk_vld_s1 &&
		((rdata_q.pri == URGENT_PRIORITY) || (chk_idx_s1 == '0));

	// Memory port selection
	always_comb begin
		rd_addr = (state_q == SHIFT) ? (sh_idx_q + AW'(1)) : scan_idx_q;
		we      = wr_vld_s1 || (accept && !s_axis_tuser && !is_full);
		waddr   = wr_vld_s1 ? wr_idx_s1 : count_q[AW-1:0];
		wdata   = wr_vld_s1 ? rdata_q : job_in;
	end

	// Entry memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[rd_addr];
	end

	assign fill_ext = FW'(count_q);

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			count_q      <= '0;
			scan_idx_q   <= '0;
			scan_run_q   <= 1'b0;
			chk_vld_s1   <= 1'b0;
			chk_idx_s1   <= '0;
			sh_idx_q     <= '0;
			wr_vld_s1    <= 1'b0;
			wr_idx_s1    <= '0;
			res_status_q <= ST_INSERTED;
			res_job_q    <= '0;
			res_urg_q    <= 1'b0;
			m_vld_q      <= 1'b0;
			m_data_q     <= '0;
			m_user_q     <= '0;
		end else begin
			// DONE reloads the output register itself
			if (m_vld_q && m_axis_tready && (state_q != DONE)) begin
				m_vld_q <= 1'b0;
			end
			case (state_q)
				IDLE: begin
					chk_vld_s1 <= 1'b0;
					wr_vld_s1  <= 1'b0;
					if (accept) begin
						res_job_q <= '0;
						res_urg_q <= 1'b0;
						if (!s_axis_tuser) begin
							state_q <= DONE;
							if (is_full) begin
								res_status_q <= ST_FULL;
							end else begin
								res_status_q <= ST_INSERTED;
								count_q      <= count_q + CW'(1);
							end
						end else if (count_q == '0) begin
							res_status_q <= ST_EMPTY;
							state_q      <= DONE;
						end else begin
							scan_idx_q <= cnt_m1[AW-1:0];
							scan_run_q <= 1'b1;
							state_q    <= SCAN;
						end
					end
				end
				SCAN: begin
					// issue reads newest first, check each one in the cycle after its read
					if (pick_hit) begin
						res_status_q <= ST_SERVED;
						res_job_q    <= rdata_q;
						res_urg_q    <= (rdata_q.pri == URGENT_PRIORITY);
						sh_idx_q     <= chk_idx_s1;
						scan_run_q   <= 1'b0;
						chk_vld_s1   <= 1'b0;
						wr_vld_s1    <= 1'b0;
						state_q      <= SHIFT;
					end else begin
						chk_vld_s1 <= scan_run_q;
						chk_idx_s1 <= scan_idx_q;
						if (scan_run_q) begin
							if (scan_idx_q == '0) begin
								scan_run_q <= 1'b0;
							end else begin
								scan_idx_q <= scan_idx_q - AW'(1);
							end
						end
					end
				end
				SHIFT: begin
					// read entry above, write it one slot down next cycle
					wr_vld_s1 <= sh_more;
					wr_idx_s1 <= sh_idx_q;
					if (sh_more) begin
						sh_idx_q <= sh_idx_q + AW'(1);
					end else if (!wr_vld_s1) begin
						count_q <= cnt_m1;
						state_q <= DONE;
					end
				end
				DONE: begin
					if (!m_vld_q || m_axis_tready) begin
						m_vld_q  <= 1'b1;
						m_user_q <= res_status_q;
						m_data_q <= {PAD_W'(0), fill_ext[FILL_W-1:0], res_urg_q,
							res_job_q.pri, res_job_q.id, res_job_q.doc};
						state_q  <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign m_axis_tvalid = m_vld_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule

@@ hw/rtl/ufjq_checker.sv @@
// Port-level checker for the urgent-first job queue, bound to the top level.
// Depends on ufjq_pkg and urgent_first_job_queue.
module ufjq_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_axis_tvalid,
	input logic                           s_axis_tready,
	input logic [ufjq_pkg::S_TDATA_W-1:0] s_axis_tdata,
	input logic                           s_axis_tuser,
	input logic                           m_axis_tvalid,
	input logic                           m_axis_tready,
	input logic [ufjq_pkg::M_TDATA_W-1:0] m_axis_tdata,
	input logic [ufjq_pkg::STATUS_W-1:0]  m_axis_tuser
);
	import ufjq_pkg::*;

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// One request in work at a time
	a_one_req: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("request taken while another is in work");

	// Served fields are zero unless a job was served
	a_zero_unserved: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != ST_SERVED) |->
			(m_axis_tdata[DOC_W+ID_W+PRI_W:0] == '0))
		else $error("served fields set without a served job");

	// An empty serve reports an empty queue
	a_empty_fill: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser == ST_EMPTY) |->
			(m_axis_tdata[DOC_W+ID_W+PRI_W+FILL_W:DOC_W+ID_W+PRI_W+1] == '0))
		else $error("empty status with nonzero fill level");

endmodule

bind urgent_first_job_queue ufjq_checker u_ufjq_checker (.*);

@@ dv/tb.sv @@
// Self-checking bench for the urgent-first job queue: a short directed table,
// then random insert/serve traffic with random stalls on both stream sides.
// Depends on ufjq_pkg and urgent_first_job_queue from hw/rtl.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ufjq_pkg::*;

	localparam int QDEPTH = DEF_QUEUE_DEPTH;
	localparam int N_RANDOM = 1000;
	localparam int LONG_HOLD = 400;
	localparam int DRAIN_CYCLES = 2 * QDEPTH + 16;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [DOC_W-1:0] DOC_MAX = {DOC_W{1'b1}};
	localparam logic [ID_W-1:0] ID_MAX = 37'd99999999999;
	localparam logic [PRI_W-1:0] PRI_MAX = {PRI_W{1'b1}};

	// One result as the block reports it
	typedef struct packed {
		status_t          st;
		logic [DOC_W-1:0] doc;
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		logic             urg;
		logic [FILL_W-1:0] fill;
	} serve_res_t;

	// One row of the directed table; typed rows carry their expected result
	typedef struct packed {
		logic             mode;
		logic [DOC_W-1:0] doc;
		logic [ID_W-1:0]  id;
		logic [PRI_W-1:0] pri;
		logic             typed;
		serve_res_t       res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	// [30:0] doc_number, [67:31] id_code, [75:68] priority_req, [79:76] zero
	logic [S_TDATA_W-1:0] s_axis_tdata = '0;
	// [0] mode
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	// [30:0] served_doc, [67:31] served_id, [75:68] served_priority,
	// [76] served_urgent, [81:77] fill_level, [87:82] zero
	logic [M_TDATA_W-1:0] m_axis_tdata;
	// [1:0] status
	logic [STATUS_W-1:0] m_axis_tuser;

	job_t model_jobs[$];
	serve_res_t pending_results[$];
	dir_row_t dir_tab[$];

	int unsigned mism_cnt = 0;
	int unsigned n_ins = 0, n_srv = 0, n_urg = 0, n_empty = 0, n_full = 0;
	bit hold_req = 1'b0;
	bit hold_done = 1'b0;
	int unsigned cyc = 0;

	urgent_first_job_queue #(
		.QUEUE_DEPTH(QDEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// Queue behavior: append on insert, take newest urgent job else oldest on serve
	task automatic predict_job_step(input logic mode, input logic [DOC_W-1:0] doc,
			input logic [ID_W-1:0] id, input logic [PRI_W-1:0] pri,
			output serve_res_t r);
		job_t j;
		int pick;
		bit found;
		r = '0;
		if (!mode) begin
			if (model_jobs.size() >= QDEPTH) begin
				r.st = ST_FULL;
			end else begin
				j.doc = doc;
				j.id = id;
				j.pri = pri;
				model_jobs.push_back(j);
				r.st = ST_INSERTED;
			end
		end else if (model_jobs.size() == 0) begin
			r.st = ST_EMPTY;
		end else begin
			pick = 0;
			found = 1'b0;
			for (int k = model_jobs.size() - 1; k >= 0; k--) begin
				if (model_jobs[k].pri == URGENT_PRIORITY) begin
					pick = k;
					found = 1'b1;
					break;
				end
			end
			r.st = ST_SERVED;
			r.doc = model_jobs[pick].doc;
			r.id = model_jobs[pick].id;
			r.pri = model_jobs[pick].pri;
			r.urg = found;
			model_jobs.delete(pick);
		end
		r.fill = FILL_W'(model_jobs.size());
	endtask

	function automatic dir_row_t mk_row(logic mode, logic [DOC_W-1:0] doc,
			logic [ID_W-1:0] id, logic [PRI_W-1:0] pri, logic typed,
			status_t st, int fill);
		dir_row_t row;
		row = '0;
		row.mode = mode;
		row.doc = doc;
		row.id = id;
		row.pri = pri;
		row.typed = typed;
		row.res.st = st;
		row.res.fill = FILL_W'(fill);
		return row;
	endfunction

	// Sender gap: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 45) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Offer one request, wait for it to be taken, then record its prediction
	task automatic offer_request(input logic mode, input logic [DOC_W-1:0] doc,
			input logic [ID_W-1:0] id, input logic [PRI_W-1:0] pri,
			input logic typed, input serve_res_t typed_res, input int unsigned gap);
		serve_res_t pred;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= mode;
		s_axis_tdata <= {4'b0, pri, id, doc};
		do @(posedge clk); while (!s_axis_tready);
		predict_job_step(mode, doc, id, pri, pred);
		pending_results.push_back(typed ? typed_res : pred);
		if (gap != 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Receiver: random ready/stall stretches, one long hold-off on request
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_done = 1'b1;
			end
			m_axis_tready <= 1'b1;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(60, 150)) @(posedge clk);
			else
				repeat ($urandom_range(1, 8)) @(posedge clk);
			m_axis_tready <= 1'b0;
			if ($urandom_range(0, 9) == 0)
				repeat ($urandom_range(15, 50)) @(posedge clk);
			else
				repeat ($urandom_range(1, 3)) @(posedge clk);
		end
	end

	// Result checker against the oldest pending expectation
	always @(posedge clk) begin
		serve_res_t got, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.st = status_t'(m_axis_tuser);
			got.doc = m_axis_tdata[30:0];
			got.id = m_axis_tdata[67:31];
			got.pri = m_axis_tdata[75:68];
			got.urg = m_axis_tdata[76];
			got.fill = m_axis_tdata[81:77];
			case (got.st)
				ST_INSERTED: n_ins++;
				ST_SERVED: begin
					n_srv++;
					if (got.urg) n_urg++;
				end
				ST_EMPTY: n_empty++;
				default: n_full++;
			endcase
			if (pending_results.size() == 0) begin
				mism_cnt++;
				if (mism_cnt <= 10)
					$display("%0t: result with nothing pending: st=%0d doc=%h id=%h",
						$realtime, got.st, got.doc, got.id);
			end else begin
				exp_r = pending_results.pop_front();
				if (got !== exp_r) begin
					mism_cnt++;
					if (mism_cnt <= 10) begin
						$display("%0t: mismatch exp st=%0d doc=%h id=%h pri=%h urg=%0d fill=%0d",
							$realtime, exp_r.st, exp_r.doc, exp_r.id, exp_r.pri,
							exp_r.urg, exp_r.fill);
						$display("%0t:          got st=%0d doc=%h id=%h pri=%h urg=%0d fill=%0d",
							$realtime, got.st, got.doc, got.id, got.pri, got.urg, got.fill);
					end
				end
			end
		end
	end

	// Watchdog
	initial begin
		while (cyc < CYCLE_LIMIT) begin
			@(posedge clk);
			cyc++;
		end
		$display("tb failed");
		$finish;
	end

	// Main sequence: reset, directed table, random traffic, drain
	initial begin
		logic mode;
		logic [DOC_W-1:0] doc;
		logic [ID_W-1:0] id;
		logic [PRI_W-1:0] pri;
		logic [63:0] wide;
		int unsigned ins_pct, r;
		dir_row_t row;

		// Empty serve, extremes, newest-urgent, oldest fallback, oldest-urgent
		dir_tab.push_back(mk_row(1'b1, '0, '0, '0, 1'b1, ST_EMPTY, 0));
		dir_tab.push_back(mk_row(1'b0, DOC_MAX, ID_MAX, PRI_MAX, 1'b1, ST_INSERTED, 1));
		dir_tab.push_back(mk_row(1'b0, '0, '0, '0, 1'b1, ST_INSERTED, 2));
		dir_tab.push_back(mk_row(1'b0, 31'h1234, 37'd5, URGENT_PRIORITY, 1'b1,
			ST_INSERTED, 3));
		dir_tab.push_back(mk_row(1'b0, 31'h55555555, 37'h0AAAAAAAAA, URGENT_PRIORITY,
			1'b1, ST_INSERTED, 4));
		dir_tab.push_back(mk_row(1'b1, '0, '0, '0, 1'b0, ST_SERVED, 0));
		dir_tab.push_back(mk_row(1'b1, '0, '0, '0, 1'b0, ST_SERVED, 0));
		dir_tab.push_back(mk_row(1'b1, '0, '0, '0, 1'b0, ST_SERVED, 0));
		dir_tab.push_back(mk_row(1'b1, '0, '0, '0, 1'b0, ST_SERVED, 0));
		dir_tab.push_back(mk_row(1'b0, 31'h2AAAAAAA, 37'h1555555555 & ID_MAX,
			URGENT_PRIORITY, 1'b1, ST_INSERTED, 1));
		dir_tab.push_back(mk_row(1'b0, 31'h777, 37'd12345678901, 8'd2, 1'b1,
			ST_INSERTED, 2));
		dir_tab.push_back(mk_row(1'b1, '0, '0, '0, 1'b0, ST_SERVED, 0));
		// Fill to the top, then a dropped insert and one serve from a full queue
		for (int i = 2; i <= QDEPTH; i++)
			dir_tab.push_back(mk_row(1'b0, 31'(i * 977),
				ID_W'(64'(i) * 64'd3141592653),
				(i % 3 == 0) ? URGENT_PRIORITY : 8'(i), 1'b1, ST_INSERTED, i));
		dir_tab.push_back(mk_row(1'b0, DOC_MAX, ID_MAX, URGENT_PRIORITY, 1'b1,
			ST_FULL, QDEPTH));
		dir_tab.push_back(mk_row(1'b1, '0, '0, '0, 1'b0, ST_SERVED, 0));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			row = dir_tab[i];
			offer_request(row.mode, row.doc, row.id, row.pri, row.typed, row.res,
				pick_gap());
		end

		// Let the directed part drain before the random traffic
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);

		ins_pct = 60;
		for (int n = 0; n < N_RANDOM; n++) begin
			// Shift the insert/serve balance so the queue fills and empties
			if (n % 100 == 0) begin
				case ((n / 100) % 4)
					0: ins_pct = 80;
					1: ins_pct = 35;
					2: ins_pct = 60;
					default: ins_pct = 20;
				endcase
			end
			if (n == 100) hold_req = 1'b1;
			if (n == 500) begin
				s_axis_tvalid <= 1'b0;
				while (pending_results.size() != 0) @(posedge clk);
			end
			mode = ($urandom_range(0, 99) >= ins_pct);
			r = $urandom_range(0, 9);
			if (r == 0) doc = '0;
			else if (r == 1) doc = DOC_MAX;
			else doc = DOC_W'($urandom);
			wide = {$urandom, $urandom};
			r = $urandom_range(0, 19);
			if (r == 0) id = '0;
			else if (r == 1) id = ID_MAX;
			else id = ID_W'(wide % 64'd100000000000);
			r = $urandom_range(0, 9);
			if (r < 4) pri = URGENT_PRIORITY;
			else if (r == 4) pri = '0;
			else if (r == 5) pri = PRI_MAX;
			else pri = PRI_W'($urandom_range(0, 255));
			// Serve requests carry random payload bits, which must be ignored
			offer_request(mode, doc, id, pri, 1'b0, '0, pick_gap());
		end

		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d inserts, %0d serves (%0d urgent), %0d empty serves, %0d drops",
			n_ins, n_srv, n_urg, n_empty, n_full);
		$display("Mismatches: %0d, results still pending: %0d", mism_cnt,
			pending_results.size());
		if (mism_cnt == 0 && pending_results.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule
